// ----- src/lmfs_pkg.sv -----
// Package with shared types, codes and limits for the lyrics metadata frame scanner.
`default_nettype none

package lmfs_pkg;

  localparam int unsigned COUNT_W         = 25;
  localparam int unsigned SIZE_W          = 28;
  localparam int unsigned NEXT_W          = 30;
  localparam int unsigned END_W           = 29;
  localparam int unsigned OFFSET_W        = 18;
  localparam int unsigned LENGTH_W        = 24;

  localparam int unsigned WALK_LIMIT      = 262144;
  localparam int unsigned PREFILTER_LIMIT = 131072;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [31:0] TAG_USLT = 32'h55534C54;
  localparam logic [31:0] TAG_SYLT = 32'h53594C54;
  localparam logic [23:0] TAG_ID3  = 24'h494433;
  localparam logic [31:0] TAG_FLAC = 32'h664C6143;
  localparam logic [31:0] TAG_VORB = 32'h564F5242;
  localparam logic [31:0] TAG_COMM = 32'h434F4D4D;

  localparam logic [6:0] LOW7_MASK        = 7'h7F;
  localparam logic [6:0] FLAC_TYPE_LYRICS = 7'd4;

  localparam logic [1:0] CONT_NONE = 2'd0;
  localparam logic [1:0] CONT_ID3  = 2'd1;
  localparam logic [1:0] CONT_FLAC = 2'd2;

  localparam logic [1:0] FK_NONE = 2'd0;
  localparam logic [1:0] FK_USLT = 2'd1;
  localparam logic [1:0] FK_SYLT = 2'd2;

  localparam logic [COUNT_W-1:0] ID3_MAGIC_END  = 25'd2;
  localparam logic [COUNT_W-1:0] FLAC_MAGIC_END = 25'd3;
  localparam logic [COUNT_W-1:0] ID3_FIRST_HDR  = 25'd10;
  localparam logic [COUNT_W-1:0] FLAC_FIRST_HDR = 25'd4;

  localparam int unsigned ID3_HDR_LEN  = 10;
  localparam int unsigned FLAC_HDR_LEN = 4;

  localparam logic [3:0] ID3_TAG_END    = 4'd3;
  localparam logic [3:0] ID3_SIZE_FIRST = 4'd4;
  localparam logic [3:0] ID3_SIZE_LAST  = 4'd7;
  localparam logic [3:0] ID3_HDR_END    = 4'd9;
  localparam logic [3:0] FLAC_TYPE_POS  = 4'd0;
  localparam logic [3:0] FLAC_HDR_END   = 4'd3;

  typedef enum logic [1:0] {
    PH_MAGIC,
    PH_WAIT,
    PH_HEADER,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic                found;
    logic                synced;
    logic [1:0]          container;
    logic [OFFSET_W-1:0] text_offset;
    logic [LENGTH_W-1:0] text_length;
  } verdict_t;

endpackage

`default_nettype wire

// ----- src/lmfs_scan.sv -----
// Per-byte header walk, prefilter and end-of-file verdict logic.
`default_nettype none

module lmfs_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  lmfs_pkg::in_beat_t beat,
  input  logic              extract_enable,
  output lmfs_pkg::verdict_t verdict
);
  import lmfs_pkg::*;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [31:0]        recent_bytes, recent_bytes_next;
  logic [1:0]         container_kind, container_kind_next;
  phase_t             phase, phase_next;
  logic [3:0]         header_index, header_index_next;
  logic [SIZE_W-1:0]  size_accum, size_accum_next;
  logic [COUNT_W-1:0] next_header_pos, next_header_pos_next;
  logic [1:0]         frame_kind, frame_kind_next;
  logic               prefilter_hit, prefilter_hit_next;
  logic               cand_valid, cand_valid_next;
  logic               cand_synced, cand_synced_next;
  logic [COUNT_W-1:0] cand_start, cand_start_next;
  logic [SIZE_W-1:0]  cand_size, cand_size_next;

  logic [31:0]        rb;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] count_inc;
  logic [NEXT_W-1:0]  nxt;
  logic [END_W-1:0]   cand_end;
  logic [COUNT_W-1:0] walk_lim;
  logic               ok;

  always_comb begin
    rb                   = {recent_bytes[23:0], beat.data};
    idx                  = byte_count;
    phase_next           = phase;
    container_kind_next  = container_kind;
    next_header_pos_next = next_header_pos;
    header_index_next    = header_index;
    size_accum_next      = size_accum;
    frame_kind_next      = frame_kind;
    prefilter_hit_next   = prefilter_hit;
    cand_valid_next      = cand_valid;
    cand_synced_next     = cand_synced;
    cand_start_next      = cand_start;
    cand_size_next       = cand_size;
    nxt                  = '0;

    if (phase == PH_MAGIC) begin
      if (idx == ID3_MAGIC_END && rb[23:0] == TAG_ID3) begin
        container_kind_next  = CONT_ID3;
        phase_next           = PH_WAIT;
        next_header_pos_next = ID3_FIRST_HDR;
      end else if (idx == FLAC_MAGIC_END && rb == TAG_FLAC) begin
        container_kind_next  = CONT_FLAC;
        phase_next           = PH_WAIT;
        next_header_pos_next = FLAC_FIRST_HDR;
      end else if (idx >= FLAC_MAGIC_END) begin
        phase_next = PH_DONE;
      end
    end

    if (idx >= FLAC_MAGIC_END && idx < COUNT_W'(PREFILTER_LIMIT)) begin
      if (container_kind_next == CONT_ID3 && (rb == TAG_USLT || rb == TAG_SYLT)) begin
        prefilter_hit_next = 1'b1;
      end
      if (container_kind_next == CONT_FLAC && (rb == TAG_VORB || rb == TAG_COMM)) begin
        prefilter_hit_next = 1'b1;
      end
    end

    if (phase_next == PH_WAIT && idx == next_header_pos_next) begin
      phase_next        = PH_HEADER;
      header_index_next = '0;
      size_accum_next   = '0;
      frame_kind_next   = FK_NONE;
    end else if (phase_next == PH_HEADER) begin
      header_index_next = header_index + 4'd1;
    end

    if (phase_next == PH_HEADER) begin
      if (container_kind_next == CONT_ID3) begin
        if (header_index_next == ID3_TAG_END) begin
          frame_kind_next = (rb == TAG_USLT) ? FK_USLT :
                            (rb == TAG_SYLT) ? FK_SYLT : FK_NONE;
        end else if (header_index_next >= ID3_SIZE_FIRST &&
                     header_index_next <= ID3_SIZE_LAST) begin
          size_accum_next = {size_accum_next[SIZE_W-8:0], beat.data[6:0] & LOW7_MASK};
        end else if (header_index_next == ID3_HDR_END) begin
          nxt = NEXT_W'(next_header_pos_next) + NEXT_W'(ID3_HDR_LEN) +
                NEXT_W'(size_accum_next);
          phase_next = PH_DONE;
          if (size_accum_next != '0) begin
            if (frame_kind_next != FK_NONE) begin
              cand_valid_next  = 1'b1;
              cand_synced_next = (frame_kind_next == FK_SYLT);
              cand_start_next  = next_header_pos_next + COUNT_W'(ID3_HDR_LEN);
              cand_size_next   = size_accum_next;
            end else if (nxt + NEXT_W'(ID3_HDR_LEN) < NEXT_W'(WALK_LIMIT)) begin
              next_header_pos_next = nxt[COUNT_W-1:0];
              phase_next           = PH_WAIT;
            end
          end
        end
      end else begin
        if (header_index_next == FLAC_TYPE_POS) begin
          frame_kind_next = {beat.data[7], beat.data[6:0] == FLAC_TYPE_LYRICS};
        end else begin
          size_accum_next = {4'd0, size_accum_next[15:0], beat.data};
          if (header_index_next == FLAC_HDR_END) begin
            nxt = NEXT_W'(next_header_pos_next) + NEXT_W'(FLAC_HDR_LEN) +
                  NEXT_W'(size_accum_next);
            phase_next = PH_DONE;
            if (frame_kind_next[0]) begin
              cand_valid_next  = 1'b1;
              cand_synced_next = 1'b0;
              cand_start_next  = next_header_pos_next + COUNT_W'(FLAC_HDR_LEN);
              cand_size_next   = size_accum_next;
            end else if (!frame_kind_next[1] &&
                         nxt + NEXT_W'(FLAC_HDR_LEN) < NEXT_W'(WALK_LIMIT)) begin
              next_header_pos_next = nxt[COUNT_W-1:0];
              phase_next           = PH_WAIT;
            end
          end
        end
      end
    end

    count_inc = (byte_count != COUNT_MAX) ? byte_count + 25'd1 : byte_count;

    // Verdict on the file as it stands after this byte.
    cand_end = END_W'(cand_start_next) + END_W'(cand_size_next);
    walk_lim = (count_inc < COUNT_W'(WALK_LIMIT)) ? count_inc : COUNT_W'(WALK_LIMIT);
    ok = 1'b0;
    if (prefilter_hit_next && cand_valid_next) begin
      if (container_kind_next == CONT_ID3) begin
        ok = cand_end <= END_W'(walk_lim);
      end else if (container_kind_next == CONT_FLAC) begin
        ok = (cand_start_next < count_inc) && (cand_end <= END_W'(count_inc));
      end
    end
    verdict.found       = ok;
    verdict.synced      = ok && cand_synced_next;
    verdict.container   = container_kind_next;
    verdict.text_offset = (ok && extract_enable) ? cand_start_next[OFFSET_W-1:0] : '0;
    verdict.text_length = (ok && extract_enable) ? cand_size_next[LENGTH_W-1:0] : '0;

    recent_bytes_next = rb;
    byte_count_next   = count_inc;

    // The final beat of a file returns every scanning register to its idle value.
    if (beat.last) begin
      byte_count_next      = '0;
      recent_bytes_next    = '0;
      container_kind_next  = CONT_NONE;
      phase_next           = PH_MAGIC;
      header_index_next    = '0;
      size_accum_next      = '0;
      next_header_pos_next = '0;
      frame_kind_next      = FK_NONE;
      prefilter_hit_next   = 1'b0;
      cand_valid_next      = 1'b0;
      cand_synced_next     = 1'b0;
      cand_start_next      = '0;
      cand_size_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      recent_bytes    <= '0;
      container_kind  <= CONT_NONE;
      phase           <= PH_MAGIC;
      header_index    <= '0;
      size_accum      <= '0;
      next_header_pos <= '0;
      frame_kind      <= FK_NONE;
      prefilter_hit   <= 1'b0;
      cand_valid      <= 1'b0;
      cand_synced     <= 1'b0;
      cand_start      <= '0;
      cand_size       <= '0;
    end else if (take) begin
      byte_count      <= byte_count_next;
      recent_bytes    <= recent_bytes_next;
      container_kind  <= container_kind_next;
      phase           <= phase_next;
      header_index    <= header_index_next;
      size_accum      <= size_accum_next;
      next_header_pos <= next_header_pos_next;
      frame_kind      <= frame_kind_next;
      prefilter_hit   <= prefilter_hit_next;
      cand_valid      <= cand_valid_next;
      cand_synced     <= cand_synced_next;
      cand_start      <= cand_start_next;
      cand_size       <= cand_size_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/lmfs_out.sv -----
// Result register holding one verdict beat until the downstream side takes it.
`default_nettype none

module lmfs_out (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  lmfs_pkg::verdict_t              verdict,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            found,
  output logic                            synced,
  output logic [1:0]                      container,
  output logic [lmfs_pkg::OFFSET_W-1:0]   text_offset,
  output logic [lmfs_pkg::LENGTH_W-1:0]   text_length
);
  import lmfs_pkg::*;

  verdict_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= verdict;
    end
  end

  assign found       = held.found;
  assign synced      = held.synced;
  assign container   = held.container;
  assign text_offset = held.text_offset;
  assign text_length = held.text_length;

endmodule

`default_nettype wire

// ----- src/lyrics_metadata_frame_scanner.sv -----
// Top level of the lyrics metadata frame scanner: input register, scanner and result register.
// A file's verdict beat is registered as its final byte leaves the input register.
// Throughput: one byte per cycle; a final byte waits in the input register only while the
// previous verdict is held in the result register and stalled.
// Reset: synchronous rst clears the scan state, the input and result valids and
// extract_enable; no clearing pass is needed.
`default_nettype none

module lyrics_metadata_frame_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic                          synced,
  output logic [1:0]                    container,
  output logic [lmfs_pkg::OFFSET_W-1:0] text_offset,
  output logic [lmfs_pkg::LENGTH_W-1:0] text_length
);
  import lmfs_pkg::*;

  logic     extract_enable;
  logic     in_q_valid;
  in_beat_t in_q;
  logic     take;
  logic     load;
  verdict_t verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      extract_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      extract_enable <= cfg_wr_data;
    end
  end

  assign in_stall = in_q_valid && in_q.last && out_valid && out_stall;
  assign take     = in_q_valid && !(in_q.last && out_valid && out_stall);
  assign load     = take && in_q.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (take) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= '{data: data_byte, last: last_byte};
    end
  end

  lmfs_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .beat           (in_q),
    .extract_enable (extract_enable),
    .verdict        (verdict)
  );

  lmfs_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .verdict     (verdict),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .found       (found),
    .synced      (synced),
    .container   (container),
    .text_offset (text_offset),
    .text_length (text_length)
  );

  a_quiet_when_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> !synced && text_offset == '0 && text_length == '0)
    else $error("verdict without a find carries lyrics details");

  a_found_needs_container: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> container == CONT_ID3 || container == CONT_FLAC)
    else $error("lyrics found in an unrecognised container");

  a_flac_not_synced: assert property (@(posedge clk) disable iff (rst)
    out_valid && container == CONT_FLAC |-> !synced)
    else $error("FLAC verdict marked as synced");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("final beat did not produce a verdict");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the lyrics metadata frame scanner, driven with byte streams of media files.
module testbench;
  import lmfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int N_DIR = 26;

  localparam verdict_t V_NONE = '{found: 1'b0, synced: 1'b0, container: CONT_NONE,
                                   text_offset: '0, text_length: '0};
  localparam verdict_t V_ID3 = '{found: 1'b0, synced: 1'b0, container: CONT_ID3,
                                  text_offset: '0, text_length: '0};
  localparam verdict_t V_FLAC = '{found: 1'b0, synced: 1'b0, container: CONT_FLAC,
                                   text_offset: '0, text_length: '0};
  localparam verdict_t V_FLAC_LYRICS = '{found: 1'b1, synced: 1'b0, container: CONT_FLAC,
                                          text_offset: '0, text_length: '0};

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    verdict_t   want;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR] = '{
    '{8'h00, 1'b1, 1'b1, V_NONE},
    '{8'hFF, 1'b1, 1'b1, V_NONE},
    '{8'h49, 1'b0, 1'b0, V_NONE},
    '{8'h44, 1'b0, 1'b0, V_NONE},
    '{8'h33, 1'b1, 1'b1, V_ID3},
    '{8'h66, 1'b0, 1'b0, V_NONE},
    '{8'h4C, 1'b0, 1'b0, V_NONE},
    '{8'h61, 1'b0, 1'b0, V_NONE},
    '{8'h43, 1'b1, 1'b1, V_FLAC},
    '{8'h66, 1'b0, 1'b0, V_NONE},
    '{8'h4C, 1'b0, 1'b0, V_NONE},
    '{8'h61, 1'b1, 1'b1, V_NONE},
    '{8'h49, 1'b0, 1'b0, V_NONE},
    '{8'h44, 1'b1, 1'b1, V_NONE},
    '{8'h66, 1'b0, 1'b0, V_NONE},
    '{8'h4C, 1'b0, 1'b0, V_NONE},
    '{8'h61, 1'b0, 1'b0, V_NONE},
    '{8'h43, 1'b0, 1'b0, V_NONE},
    '{8'h84, 1'b0, 1'b0, V_NONE},
    '{8'h00, 1'b0, 1'b0, V_NONE},
    '{8'h00, 1'b0, 1'b0, V_NONE},
    '{8'h04, 1'b0, 1'b0, V_NONE},
    '{8'h43, 1'b0, 1'b0, V_NONE},
    '{8'h4F, 1'b0, 1'b0, V_NONE},
    '{8'h4D, 1'b0, 1'b0, V_NONE},
    '{8'h4D, 1'b1, 1'b1, V_FLAC_LYRICS}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          data_byte = 8'h00;
  logic                last_byte = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                found;
  logic                synced;
  logic [1:0]          container;
  logic [OFFSET_W-1:0] text_offset;
  logic [LENGTH_W-1:0] text_length;

  lyrics_metadata_frame_scanner u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .synced      (synced),
    .container   (container),
    .text_offset (text_offset),
    .text_length (text_length)
  );

  // Scanner state as the block should hold it.
  logic               ext_en;
  logic [COUNT_W-1:0] pos;
  logic [31:0]        window;
  logic [1:0]         kind;
  phase_t             phase;
  logic [3:0]         hdr_idx;
  logic [SIZE_W-1:0]  size_sum;
  logic [31:0]        next_pos;
  logic [1:0]         frame_tag;
  logic               pre_hit;
  logic               cand_ok;
  logic               cand_sync;
  logic [31:0]        cand_start;
  logic [SIZE_W-1:0]  cand_len;

  verdict_t    pending_verdicts [$];
  logic [7:0]  file_q [$];
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  function automatic void clear_scan_state();
    pos = '0;
    window = '0;
    kind = CONT_NONE;
    phase = PH_MAGIC;
    hdr_idx = '0;
    size_sum = '0;
    next_pos = '0;
    frame_tag = FK_NONE;
    pre_hit = 1'b0;
    cand_ok = 1'b0;
    cand_sync = 1'b0;
    cand_start = '0;
    cand_len = '0;
  endfunction

  function automatic bit scan_byte(input logic [7:0] b, input logic fin, output verdict_t v);
    logic [COUNT_W-1:0] at;
    longint unsigned    nxt;
    longint unsigned    fsize;
    longint unsigned    endp;
    longint unsigned    lim;
    logic               ok;
    at = pos;
    v = '0;
    window = {window[23:0], b};

    if (phase == PH_MAGIC) begin
      if (at == ID3_MAGIC_END && window[23:0] == TAG_ID3) begin
        kind = CONT_ID3;
        phase = PH_WAIT;
        next_pos = 32'(ID3_FIRST_HDR);
      end else if (at == FLAC_MAGIC_END && window == TAG_FLAC) begin
        kind = CONT_FLAC;
        phase = PH_WAIT;
        next_pos = 32'(FLAC_FIRST_HDR);
      end else if (at >= FLAC_MAGIC_END) begin
        phase = PH_DONE;
      end
    end

    if (at >= FLAC_MAGIC_END && at < PREFILTER_LIMIT) begin
      if (kind == CONT_ID3 && (window == TAG_USLT || window == TAG_SYLT)) pre_hit = 1'b1;
      if (kind == CONT_FLAC && (window == TAG_VORB || window == TAG_COMM)) pre_hit = 1'b1;
    end

    if (phase == PH_WAIT && 32'(at) == next_pos) begin
      phase = PH_HEADER;
      hdr_idx = '0;
      size_sum = '0;
      frame_tag = FK_NONE;
    end else if (phase == PH_HEADER) begin
      hdr_idx = hdr_idx + 4'd1;
    end

    if (phase == PH_HEADER) begin
      if (kind == CONT_ID3) begin
        if (hdr_idx == ID3_TAG_END) begin
          frame_tag = (window == TAG_USLT) ? FK_USLT : (window == TAG_SYLT) ? FK_SYLT : FK_NONE;
        end else if (hdr_idx >= ID3_SIZE_FIRST && hdr_idx <= ID3_SIZE_LAST) begin
          size_sum = {size_sum[SIZE_W-8:0], b[6:0] & LOW7_MASK};
        end else if (hdr_idx == ID3_HDR_END) begin
          nxt = longint'(next_pos) + ID3_HDR_LEN + longint'(size_sum);
          phase = PH_DONE;
          if (size_sum != '0) begin
            if (frame_tag != FK_NONE) begin
              cand_ok = 1'b1;
              cand_sync = (frame_tag == FK_SYLT);
              cand_start = next_pos + ID3_HDR_LEN;
              cand_len = size_sum;
            end else if (nxt + ID3_HDR_LEN < WALK_LIMIT) begin
              next_pos = 32'(nxt);
              phase = PH_WAIT;
            end
          end
        end
      end else begin
        // For FLAC, bit 0 marks a lyrics block and bit 1 the last block.
        if (hdr_idx == FLAC_TYPE_POS) begin
          frame_tag = {b[7], b[6:0] == FLAC_TYPE_LYRICS};
        end else begin
          size_sum = {4'b0, size_sum[15:0], b};
          if (hdr_idx == FLAC_HDR_END) begin
            nxt = longint'(next_pos) + FLAC_HDR_LEN + longint'(size_sum);
            phase = PH_DONE;
            if (frame_tag[0]) begin
              cand_ok = 1'b1;
              cand_sync = 1'b0;
              cand_start = next_pos + FLAC_HDR_LEN;
              cand_len = size_sum;
            end else if (!frame_tag[1] && nxt + FLAC_HDR_LEN < WALK_LIMIT) begin
              next_pos = 32'(nxt);
              phase = PH_WAIT;
            end
          end
        end
      end
    end

    if (pos != COUNT_MAX) pos = pos + 1'b1;
    if (!fin) return 1'b0;

    fsize = longint'(pos);
    endp = longint'(cand_start) + longint'(cand_len);
    lim = (fsize < WALK_LIMIT) ? fsize : WALK_LIMIT;
    ok = 1'b0;
    if (pre_hit && cand_ok) begin
      if (kind == CONT_ID3) ok = (endp <= lim);
      else if (kind == CONT_FLAC) ok = (longint'(cand_start) < fsize) && (endp <= fsize);
    end
    v.found = ok;
    v.synced = ok && cand_sync;
    v.container = kind;
    if (ok && ext_en) begin
      v.text_offset = cand_start[OFFSET_W-1:0];
      v.text_length = cand_len[LENGTH_W-1:0];
    end
    clear_scan_state();
    return 1'b1;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void push_word(logic [31:0] w, int n);
    for (int k = n - 1; k >= 0; k--) file_q.push_back(w[8*k +: 8]);
  endfunction

  function automatic void push_noise(int unsigned n);
    repeat (n) file_q.push_back(8'($urandom()));
  endfunction

  function automatic logic [31:0] pick_tag();
    case ($urandom_range(0, 3))
      0: return TAG_USLT;
      1: return TAG_SYLT;
      2: return TAG_VORB;
      default: return TAG_COMM;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return SIZE_W'($urandom());
    return SIZE_W'($urandom_range(1, 24));
  endfunction

  function automatic void push_payload(logic [SIZE_W-1:0] n);
    int unsigned a;
    if (n > 64) begin
      push_noise($urandom_range(0, 16));
    end else if (n >= 4 && $urandom_range(0, 2) == 0) begin
      a = $urandom_range(0, n - 4);
      push_noise(a);
      push_word(pick_tag(), 4);
      push_noise(n - 4 - a);
    end else begin
      push_noise(n);
    end
  endfunction

  function automatic void push_id3_size(logic [SIZE_W-1:0] s);
    for (int j = 3; j >= 0; j--) file_q.push_back({1'($urandom_range(0, 1)), s[7*j +: 7]});
  endfunction

  function automatic void cut_or_pad();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) if (file_q.size() > 1) void'(file_q.pop_back());
    end else if ($urandom_range(0, 4) == 0) begin
      push_noise($urandom_range(1, 10));
    end
  endfunction

  function automatic void build_id3();
    logic [SIZE_W-1:0] sz;
    int unsigned       n;
    file_q.delete();
    push_word(TAG_ID3, 3);
    push_noise(7);
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: push_word(TAG_USLT, 4);
        1: push_word(TAG_SYLT, 4);
        2: push_word(32'h54495432, 4);
        default: push_noise(4);
      endcase
      sz = pick_size();
      push_id3_size(sz);
      push_noise(2);
      push_payload(sz);
    end
    cut_or_pad();
  endfunction

  function automatic void build_flac();
    logic [23:0] sz;
    logic [6:0]  btype;
    logic        is_last;
    int unsigned n;
    file_q.delete();
    push_word(TAG_FLAC, 4);
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: btype = FLAC_TYPE_LYRICS;
        1: btype = 7'($urandom());
        default: btype = 7'($urandom_range(0, 6));
      endcase
      is_last = (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
      sz = 24'(pick_size());
      file_q.push_back({is_last, btype});
      push_word({8'h00, sz}, 3);
      push_payload(SIZE_W'(sz));
    end
    cut_or_pad();
  endfunction

  function automatic void build_noise();
    file_q.delete();
    case ($urandom_range(0, 3))
      0: push_noise($urandom_range(1, 30));
      1: begin
        if ($urandom_range(0, 1) == 0) push_word(TAG_ID3 ^ (32'd1 << $urandom_range(0, 23)), 3);
        else push_word(TAG_FLAC ^ (32'd1 << $urandom_range(0, 31)), 4);
        push_noise($urandom_range(0, 12));
        push_word(pick_tag(), 4);
        push_noise($urandom_range(0, 8));
      end
      2: begin
        if ($urandom_range(0, 1) == 0) push_word(TAG_ID3, 3);
        else push_word(TAG_FLAC, 4);
        push_noise($urandom_range(0, 20));
        push_word(pick_tag(), 4);
        push_noise($urandom_range(0, 20));
      end
      default: begin
        push_word(($urandom_range(0, 1) == 0) ? TAG_FLAC : {TAG_ID3, 8'h00}, 4);
        repeat ($urandom_range(1, 3)) void'(file_q.pop_back());
      end
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic fin, input logic typed,
                          input verdict_t want);
    verdict_t    v;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    do @(posedge clk); while (in_stall);
    if (scan_byte(b, fin, v)) pending_verdicts.push_back(typed ? want : v);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) put_byte(file_q[i], i == file_q.size() - 1, 1'b0, V_NONE);
    files_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_extract(input logic en);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    ext_en = en;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_files(input int unsigned n_bytes, input int unsigned n_files);
    int unsigned byte_goal;
    int unsigned file_goal;
    byte_goal = bytes_sent + n_bytes;
    file_goal = files_sent + n_files;
    while (bytes_sent < byte_goal || files_sent < file_goal) begin
      case ($urandom_range(0, 7))
        0, 1, 2: build_id3();
        3, 4, 5: build_flac();
        default: build_noise();
      endcase
      send_file();
      if ($urandom_range(0, 9) == 0) quiesce();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // The receiver moves among three stall behaviours: never, now and then, and mostly stalled.
  always @(negedge clk) begin
    logic s;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: s = 1'b0;
      1: s = ($urandom_range(0, 2) == 0);
      default: s = ($urandom_range(0, 3) != 0);
    endcase
    out_stall <= s;
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict beat arrived with none expected");
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("found", want.found, found);
        check_field("synced", want.synced, synced);
        check_field("container", want.container, container);
        check_field("text_offset", want.text_offset, text_offset);
        check_field("text_length", want.text_length, text_length);
      end
    end
  end

  initial begin
    ext_en = 1'b0;
    clear_scan_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      put_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].want);
    end

    quiesce();
    set_extract(1'b1);
    random_files(600, 24);

    quiesce();
    set_extract(1'b0);
    random_files(600, 24);

    quiesce();
    set_extract(1'b1);
    random_files(60, 4);

    quiesce();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
